@@ rtl/core/kpec_pkg.sv @@
package kpec_pkg;

    localparam int KEYS_MAX = 8;
    localparam int KEYS_DEF = 8;

    localparam int TICK_W  = 16;
    localparam int MASK_W  = 8;
    localparam int STATE_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [TICK_W-1:0] PRESS_MAX = 16'd65535;
    localparam logic [TICK_W-1:0] IDLE_MAX  = 16'd50000;

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STUCK_THR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DBL_IVL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_EN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_EN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STUCK_EN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DBL_EN    = 3'd7;

    localparam logic [TICK_W-1:0] HOLD_THR_RST  = 16'd50;
    localparam logic [TICK_W-1:0] LONG_THR_RST  = 16'd100;
    localparam logic [TICK_W-1:0] STUCK_THR_RST = 16'd1000;
    localparam logic [TICK_W-1:0] DBL_IVL_RST   = 16'd30;
    localparam logic [MASK_W-1:0] HOLD_EN_RST   = 8'h00;
    localparam logic [MASK_W-1:0] LONG_EN_RST   = 8'hFF;
    localparam logic [MASK_W-1:0] STUCK_EN_RST  = 8'h00;
    localparam logic [MASK_W-1:0] DBL_EN_RST    = 8'h00;

    typedef enum logic [STATE_W-1:0] {
        ST_IDLE   = 3'd0,
        ST_PRESS  = 3'd1,
        ST_HOLD   = 3'd2,
        ST_LONG   = 3'd3,
        ST_STUCK  = 3'd4,
        ST_DOUBLE = 3'd5
    } t_key_state;

    typedef struct packed {
        logic [TICK_W-1:0] hold_thr;
        logic [TICK_W-1:0] long_thr;
        logic [TICK_W-1:0] stuck_thr;
        logic [TICK_W-1:0] dbl_ivl;
        logic              hold_en;
        logic              long_en;
        logic              stuck_en;
        logic              dbl_en;
    } t_lane_cfg;

    typedef struct packed {
        t_key_state cur;
        t_key_state prev;
        logic       changed;
    } t_lane_res;

endpackage

@@ rtl/core/kpec_if.sv @@
interface kpec_in_if;
    logic                           valid;
    logic                           ready;
    logic [kpec_pkg::MASK_W-1:0]    key_levels;

    modport source (output valid, output key_levels, input ready);
    modport sink (input valid, input key_levels, output ready);
endinterface

interface kpec_out_if;
    logic                                            valid;
    logic                                            ready;
    logic [kpec_pkg::KEYS_MAX*kpec_pkg::STATE_W-1:0] current_states;
    logic [kpec_pkg::KEYS_MAX*kpec_pkg::STATE_W-1:0] previous_states;
    logic [kpec_pkg::KEYS_MAX-1:0]                   changed_mask;

    modport source (output valid, output current_states, output previous_states,
                    output changed_mask, input ready);
    modport sink (input valid, input current_states, input previous_states,
                  input changed_mask, output ready);
endinterface

@@ rtl/core/kpec_lane.sv @@
module kpec_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_down,
    input  kpec_pkg::t_lane_cfg   i_cfg,
    output kpec_pkg::t_lane_res   o_res
);

    kpec_pkg::t_key_state             r_state, n_state;
    kpec_pkg::t_key_state             r_prior, n_prior;
    logic [kpec_pkg::TICK_W-1:0]      r_press, n_press;
    logic [kpec_pkg::TICK_W-1:0]      r_idle, n_idle;
    logic [kpec_pkg::TICK_W-1:0]      press_inc;
    logic                             changed;

    assign press_inc = (r_press < kpec_pkg::PRESS_MAX) ? r_press + 16'd1 : r_press;

    always_comb begin
        n_state = r_state;
        n_prior = r_prior;
        n_press = r_press;
        n_idle  = r_idle;
        if (r_state == kpec_pkg::ST_IDLE) begin
            if (i_down) begin
                n_prior = r_state;
                n_press = '0;
                if (r_prior == kpec_pkg::ST_PRESS && r_idle < i_cfg.dbl_ivl && i_cfg.dbl_en) begin
                    n_state = kpec_pkg::ST_DOUBLE;
                end else begin
                    n_state = kpec_pkg::ST_PRESS;
                end
            end else if (r_idle < kpec_pkg::IDLE_MAX) begin
                n_idle = r_idle + 16'd1;
            end
        end else if (!i_down) begin
            n_prior = r_state;
            n_state = kpec_pkg::ST_IDLE;
            n_press = '0;
            n_idle  = '0;
        end else begin
            n_press = press_inc;
            priority if (r_state == kpec_pkg::ST_PRESS && press_inc > i_cfg.hold_thr
                         && i_cfg.hold_en) begin
                n_prior = r_state;
                n_state = kpec_pkg::ST_HOLD;
            end else if ((r_state == kpec_pkg::ST_PRESS || r_state == kpec_pkg::ST_HOLD)
                         && press_inc > i_cfg.long_thr && i_cfg.long_en) begin
                n_prior = r_state;
                n_state = kpec_pkg::ST_LONG;
            end else if ((r_state == kpec_pkg::ST_PRESS || r_state == kpec_pkg::ST_HOLD
                          || r_state == kpec_pkg::ST_LONG)
                         && press_inc > i_cfg.stuck_thr && i_cfg.stuck_en) begin
                n_prior = r_state;
                n_state = kpec_pkg::ST_STUCK;
            end else begin
                n_state = r_state;
            end
        end
    end

    assign changed = (n_state != r_state)
                     || (r_state == kpec_pkg::ST_IDLE && i_down);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kpec_pkg::ST_IDLE;
            r_prior <= kpec_pkg::ST_IDLE;
            r_press <= '0;
            r_idle  <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_prior <= n_prior;
            r_press <= n_press;
            r_idle  <= n_idle;
        end
    end

    assign o_res.cur     = n_state;
    assign o_res.prev    = n_prior;
    assign o_res.changed = changed;

endmodule

@@ rtl/core/kpec_merge.sv @@
module kpec_merge #(
    parameter int KEYS = kpec_pkg::KEYS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_can_push,
    input  kpec_pkg::t_lane_res    i_lanes [KEYS],
    kpec_out_if.source             o_rsp
);

    localparam int ST_BITS = kpec_pkg::KEYS_MAX * kpec_pkg::STATE_W;

    typedef struct packed {
        logic [ST_BITS-1:0]            cur;
        logic [ST_BITS-1:0]            prev;
        logic [kpec_pkg::KEYS_MAX-1:0] chg;
    } t_rsp;

    t_rsp   packed_rsp;
    t_rsp   r_out;
    t_rsp   r_skid;
    logic   r_out_vld;
    logic   r_skid_vld;
    logic   take;

    always_comb begin
        packed_rsp = '0;
        for (int k = 0; k < KEYS; k++) begin
            packed_rsp.cur[k*kpec_pkg::STATE_W +: kpec_pkg::STATE_W]  = i_lanes[k].cur;
            packed_rsp.prev[k*kpec_pkg::STATE_W +: kpec_pkg::STATE_W] = i_lanes[k].prev;
            packed_rsp.chg[k] = i_lanes[k].changed;
        end
    end

    assign take       = r_out_vld && o_rsp.ready;
    assign o_can_push = !r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_vld || take) begin
                r_out     <= packed_rsp;
                r_out_vld <= 1'b1;
            end else begin
                r_skid     <= packed_rsp;
                r_skid_vld <= 1'b1;
            end
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.current_states  = r_out.cur;
    assign o_rsp.previous_states = r_out.prev;
    assign o_rsp.changed_mask    = r_out.chg;

endmodule

@@ rtl/core/key_press_event_classifier_unit.sv @@
// A result is registered at the output, or in the skid entry if that stalls.
// One request per cycle while ready; every key lane updates in the same cycle.
// A two-entry output buffer keeps requests flowing while one result waits.
// Reset (synchronous, active low) sets every key idle, clears both timers,
// empties the output buffer and loads the default register values.
module key_press_event_classifier_unit #(
    parameter int KEYS = kpec_pkg::KEYS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [kpec_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [kpec_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    kpec_in_if.sink                             i_req,
    kpec_out_if.source                          o_rsp
);

    logic [kpec_pkg::TICK_W-1:0] r_hold_thr;
    logic [kpec_pkg::TICK_W-1:0] r_long_thr;
    logic [kpec_pkg::TICK_W-1:0] r_stuck_thr;
    logic [kpec_pkg::TICK_W-1:0] r_dbl_ivl;
    logic [kpec_pkg::MASK_W-1:0] r_hold_en;
    logic [kpec_pkg::MASK_W-1:0] r_long_en;
    logic [kpec_pkg::MASK_W-1:0] r_stuck_en;
    logic [kpec_pkg::MASK_W-1:0] r_dbl_en;

    logic                        can_push;
    logic                        step;
    kpec_pkg::t_lane_res         lane_res [KEYS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_thr  <= kpec_pkg::HOLD_THR_RST;
            r_long_thr  <= kpec_pkg::LONG_THR_RST;
            r_stuck_thr <= kpec_pkg::STUCK_THR_RST;
            r_dbl_ivl   <= kpec_pkg::DBL_IVL_RST;
            r_hold_en   <= kpec_pkg::HOLD_EN_RST;
            r_long_en   <= kpec_pkg::LONG_EN_RST;
            r_stuck_en  <= kpec_pkg::STUCK_EN_RST;
            r_dbl_en    <= kpec_pkg::DBL_EN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kpec_pkg::CFG_HOLD_THR:  r_hold_thr  <= i_cfg_data;
                kpec_pkg::CFG_LONG_THR:  r_long_thr  <= i_cfg_data;
                kpec_pkg::CFG_STUCK_THR: r_stuck_thr <= i_cfg_data;
                kpec_pkg::CFG_DBL_IVL:   r_dbl_ivl   <= i_cfg_data;
                kpec_pkg::CFG_HOLD_EN:   r_hold_en   <= i_cfg_data[kpec_pkg::MASK_W-1:0];
                kpec_pkg::CFG_LONG_EN:   r_long_en   <= i_cfg_data[kpec_pkg::MASK_W-1:0];
                kpec_pkg::CFG_STUCK_EN:  r_stuck_en  <= i_cfg_data[kpec_pkg::MASK_W-1:0];
                kpec_pkg::CFG_DBL_EN:    r_dbl_en    <= i_cfg_data[kpec_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_req.ready = can_push;
    assign step        = i_req.valid && can_push;

    for (genvar k = 0; k < KEYS; k++) begin : g_lane
        kpec_pkg::t_lane_cfg lane_cfg;

        assign lane_cfg.hold_thr  = r_hold_thr;
        assign lane_cfg.long_thr  = r_long_thr;
        assign lane_cfg.stuck_thr = r_stuck_thr;
        assign lane_cfg.dbl_ivl   = r_dbl_ivl;
        assign lane_cfg.hold_en   = r_hold_en[k];
        assign lane_cfg.long_en   = r_long_en[k];
        assign lane_cfg.stuck_en  = r_stuck_en[k];
        assign lane_cfg.dbl_en    = r_dbl_en[k];

        kpec_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (step),
            .i_down  (i_req.key_levels[k]),
            .i_cfg   (lane_cfg),
            .o_res   (lane_res[k])
        );
    end

    kpec_merge #(
        .KEYS (KEYS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (step),
        .o_can_push (can_push),
        .i_lanes    (lane_res),
        .o_rsp      (o_rsp)
    );

endmodule
